/* rtl/hts_pkg.sv */
// Shared types and constants for the heater thermostat self test unit.
package hts_pkg;

   localparam int unsigned SAMPLE_W = 10;
   localparam int unsigned SUM_W    = 17;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned WINDOW_W = 8;
   localparam int unsigned FAULT_W  = 8;
   localparam int unsigned CSR_W    = 17;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [COUNT_W-1:0]  SAMPLES_PER_AVERAGE = 7'd100;
   localparam logic [WINDOW_W-1:0] WINDOWS_PER_TEST    = 8'd250;
   localparam logic [FAULT_W-1:0]  FAULT_SATURATE      = 8'd255;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_SUM     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_SUM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_LIM  = 3'd4;

   localparam logic [SAMPLE_W-1:0] PROBE_LOW_RESET  = 10'd10;
   localparam logic [SAMPLE_W-1:0] PROBE_HIGH_RESET = 10'd1010;
   localparam logic [SUM_W-1:0]    ON_SUM_RESET     = 17'd0;
   localparam logic [SUM_W-1:0]    OFF_SUM_RESET    = 17'd102300;
   localparam logic [FAULT_W-1:0]  FAULT_LIM_RESET  = 8'd50;

   typedef struct packed {
      logic [SAMPLE_W-1:0] probe_low_limit;
      logic [SAMPLE_W-1:0] probe_high_limit;
      logic [SUM_W-1:0]    on_sum_threshold;
      logic [SUM_W-1:0]    off_sum_threshold;
      logic [FAULT_W-1:0]  fault_limit;
   } cfg_type;

   typedef struct packed {
      logic                heater_drive;
      logic                test_done;
      logic                heater_ok;
      logic [FAULT_W-1:0]  faults_seen;
   } result_type;

endpackage

/* rtl/hts_cfg.sv */
// Configuration register file for the heater thermostat self test unit.
module hts_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [hts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hts_pkg::CSR_W-1:0]           csr_write_data,
   output hts_pkg::cfg_type                    cfg
);

   hts_pkg::cfg_type cfg_ff;
   hts_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            hts_pkg::CSR_PROBE_LOW:
               cfg_in.probe_low_limit = csr_write_data[hts_pkg::SAMPLE_W-1:0];
            hts_pkg::CSR_PROBE_HIGH:
               cfg_in.probe_high_limit = csr_write_data[hts_pkg::SAMPLE_W-1:0];
            hts_pkg::CSR_ON_SUM:
               cfg_in.on_sum_threshold = csr_write_data[hts_pkg::SUM_W-1:0];
            hts_pkg::CSR_OFF_SUM:
               cfg_in.off_sum_threshold = csr_write_data[hts_pkg::SUM_W-1:0];
            hts_pkg::CSR_FAULT_LIM:
               cfg_in.fault_limit = csr_write_data[hts_pkg::FAULT_W-1:0];
            default: begin
               // Writes to unused indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.probe_low_limit   <= hts_pkg::PROBE_LOW_RESET;
         cfg_ff.probe_high_limit  <= hts_pkg::PROBE_HIGH_RESET;
         cfg_ff.on_sum_threshold  <= hts_pkg::ON_SUM_RESET;
         cfg_ff.off_sum_threshold <= hts_pkg::OFF_SUM_RESET;
         cfg_ff.fault_limit       <= hts_pkg::FAULT_LIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/hts_core.sv */
// Window sequencing, sum accumulation and hysteresis decision for one sample.
module hts_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [hts_pkg::SAMPLE_W-1:0]    sample,
   input  hts_pkg::cfg_type                cfg,
   output hts_pkg::result_type             result
);

   logic                           acc_ff, acc_in;
   logic [hts_pkg::COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [hts_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [hts_pkg::WINDOW_W-1:0]   win_ff, win_in;
   logic [hts_pkg::FAULT_W-1:0]    flt_ff, flt_in;
   logic                           heat_ff, heat_in;
   logic                           verd_ff, verd_in;

   logic [hts_pkg::SUM_W-1:0]      sum_next;
   logic [hts_pkg::COUNT_W-1:0]    cnt_next;
   logic                           probe_fault;
   logic                           window_end;
   logic                           done;
   logic [hts_pkg::FAULT_W-1:0]    faults_out;

   assign sum_next = sum_ff + {{(hts_pkg::SUM_W - hts_pkg::SAMPLE_W){1'b0}}, sample};
   assign cnt_next = cnt_ff + 1'b1;
   assign probe_fault = (sample < cfg.probe_low_limit) || (sample > cfg.probe_high_limit);

   always_comb begin
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      win_in     = win_ff;
      flt_in     = flt_ff;
      heat_in    = heat_ff;
      verd_in    = verd_ff;
      window_end = 1'b0;
      done       = 1'b0;

      if (!acc_ff) begin
         if (probe_fault) begin
            if (flt_ff != hts_pkg::FAULT_SATURATE) begin
               flt_in = flt_ff + 1'b1;
            end
            window_end = 1'b1;
         end else begin
            acc_in = 1'b1;
            cnt_in = '0;
            sum_in = '0;
         end
      end else begin
         sum_in = sum_next;
         cnt_in = cnt_next;
         if (cnt_next >= hts_pkg::SAMPLES_PER_AVERAGE) begin
            // Off wins when the thresholds overlap.
            if (sum_next <= cfg.on_sum_threshold) begin
               heat_in = 1'b1;
            end
            if (sum_next >= cfg.off_sum_threshold) begin
               heat_in = 1'b0;
            end
            acc_in     = 1'b0;
            cnt_in     = '0;
            window_end = 1'b1;
         end
      end

      if (window_end) begin
         win_in = win_ff + 1'b1;
         if (win_in >= hts_pkg::WINDOWS_PER_TEST) begin
            done = 1'b1;
         end
      end

      faults_out = flt_in;

      if (done) begin
         heat_in = 1'b0;
         verd_in = (flt_in <= cfg.fault_limit);
         win_in  = '0;
         flt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 1'b0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
         win_ff  <= '0;
         flt_ff  <= '0;
         heat_ff <= 1'b0;
         verd_ff <= 1'b0;
      end else if (accept) begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         win_ff  <= win_in;
         flt_ff  <= flt_in;
         heat_ff <= heat_in;
         verd_ff <= verd_in;
      end
   end

   assign result.heater_drive = heat_in;
   assign result.test_done    = done;
   assign result.heater_ok    = verd_in;
   assign result.faults_seen  = faults_out;

endmodule

/* rtl/heater_thermostat_self_test_unit.sv */
// Top level of the heater thermostat self test unit.
//
//   Channel   Direction  Handshake                       Payload
//   req_      in         req_valid / req_ready           req_adc_sample
//   rsp_      out        rsp_valid / rsp_ready           heater_drive, test_done,
//                                                        heater_ok, faults_seen
//   csr_      in         csr_write_enable                csr_index, csr_write_data
//
// One transaction in per cycle unless the output side stalls; its result appears in the
// output register on the following cycle. The window state and the result register
// sit on either side of the sum add, the probe and threshold compares and the counter
// updates. A new transaction is taken while the held result is being taken in the same
// cycle; only a stalled, full output register holds off the input side.
// Reset is synchronous; it loads the configuration defaults and clears all but rsp_ff.
module heater_thermostat_self_test_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hts_pkg::SAMPLE_W-1:0]       req_adc_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_heater_drive,
   output logic                               rsp_test_done,
   output logic                               rsp_heater_ok,
   output logic [hts_pkg::FAULT_W-1:0]        rsp_faults_seen,
   input  logic                               csr_write_enable,
   input  logic [hts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hts_pkg::CSR_W-1:0]          csr_write_data
);

   hts_pkg::cfg_type    cfg;
   hts_pkg::result_type result;
   hts_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   hts_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   hts_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_adc_sample),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_heater_drive = rsp_ff.heater_drive;
   assign rsp_test_done    = rsp_ff.test_done;
   assign rsp_heater_ok    = rsp_ff.heater_ok;
   assign rsp_faults_seen  = rsp_ff.faults_seen;

   // Every accepted transaction leaves a result in the output register.
   a_accept_gives_result: assert property (
      @(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff
   ) else $error("accepted transaction produced no result");

   // The heater is always forced off at the end of a test.
   a_done_heater_off: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.test_done) |-> !rsp_ff.heater_drive
   ) else $error("heater left on at end of test");

   // The verdict reported with the end of a test matches the final fault count.
   a_done_verdict: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.test_done) |->
         (rsp_ff.heater_ok == (rsp_ff.faults_seen <= cfg.fault_limit))
   ) else $error("verdict does not match fault count");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the heater thermostat self test unit.
`timescale 1ns / 1ps

module tb;

   typedef logic [hts_pkg::SAMPLE_W-1:0]  sample_type;
   typedef logic [hts_pkg::SUM_W-1:0]     sum_type;
   typedef logic [hts_pkg::FAULT_W-1:0]   fault_type;
   typedef logic [hts_pkg::CSR_W-1:0]     csr_data_type;
   typedef logic [hts_pkg::CSR_IDX_W-1:0] csr_idx_type;

   localparam int SAMPLE_MAX = (1 << hts_pkg::SAMPLE_W) - 1;
   localparam csr_data_type CSR_ALL_ONES = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   sample_type           req_adc_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_heater_drive;
   logic                 rsp_test_done;
   logic                 rsp_heater_ok;
   fault_type            rsp_faults_seen;
   logic                 csr_write_enable = 1'b0;
   csr_idx_type          csr_index = '0;
   csr_data_type         csr_write_data = '0;

   // Shadow copy of the unit's registers and window state.
   hts_pkg::cfg_type                      settings;
   logic                                  in_window;
   logic [hts_pkg::COUNT_W-1:0]           window_fill;
   sum_type                               window_total;
   logic [hts_pkg::WINDOW_W-1:0]          windows_closed;
   fault_type                             fault_tally;
   logic                                  heater_on;
   logic                                  test_passed;
   int                                    tests_finished = 0;

   hts_pkg::result_type awaited_reports[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int window_level = 0;
   int window_jitter = 0;

   heater_thermostat_self_test_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heater_drive (rsp_heater_drive),
      .rsp_test_done    (rsp_test_done),
      .rsp_heater_ok    (rsp_heater_ok),
      .rsp_faults_seen  (rsp_faults_seen),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, or a long hold-off counted here once requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_reports
      hts_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $error("unexpected transaction: no result was due");
            mismatches++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_heater_drive !== want.heater_drive) begin
               $error("heater_drive: expected %0d, got %0d", want.heater_drive,
                      rsp_heater_drive);
               mismatches++;
            end
            if (rsp_test_done !== want.test_done) begin
               $error("test_done: expected %0d, got %0d", want.test_done, rsp_test_done);
               mismatches++;
            end
            if (rsp_heater_ok !== want.heater_ok) begin
               $error("heater_ok: expected %0d, got %0d", want.heater_ok, rsp_heater_ok);
               mismatches++;
            end
            if (rsp_faults_seen !== want.faults_seen) begin
               $error("faults_seen: expected %0d, got %0d", want.faults_seen,
                      rsp_faults_seen);
               mismatches++;
            end
         end
      end
   end

   function automatic void reset_shadow();
      settings.probe_low_limit   = hts_pkg::PROBE_LOW_RESET;
      settings.probe_high_limit  = hts_pkg::PROBE_HIGH_RESET;
      settings.on_sum_threshold  = hts_pkg::ON_SUM_RESET;
      settings.off_sum_threshold = hts_pkg::OFF_SUM_RESET;
      settings.fault_limit       = hts_pkg::FAULT_LIM_RESET;
      in_window      = 1'b0;
      window_fill    = '0;
      window_total   = '0;
      windows_closed = '0;
      fault_tally    = '0;
      heater_on      = 1'b0;
      test_passed    = 1'b0;
   endfunction

   function automatic hts_pkg::result_type predict_report(input sample_type reading);
      hts_pkg::result_type report;
      logic                ends_window;
      logic                ends_test;
      fault_type           faults_now;
      ends_window = 1'b0;
      ends_test   = 1'b0;
      if (!in_window) begin
         if (reading < settings.probe_low_limit || reading > settings.probe_high_limit) begin
            if (fault_tally != hts_pkg::FAULT_SATURATE) fault_tally = fault_tally + 1'b1;
            ends_window = 1'b1;
         end else begin
            // An in-band probe is dropped; summing starts with the next reading.
            in_window    = 1'b1;
            window_fill  = '0;
            window_total = '0;
         end
      end else begin
         window_total = window_total + sum_type'(reading);
         window_fill  = window_fill + 1'b1;
         if (window_fill >= hts_pkg::SAMPLES_PER_AVERAGE) begin
            // Off is applied last, so it wins when the thresholds overlap.
            if (window_total <= settings.on_sum_threshold) heater_on = 1'b1;
            if (window_total >= settings.off_sum_threshold) heater_on = 1'b0;
            in_window   = 1'b0;
            window_fill = '0;
            ends_window = 1'b1;
         end
      end
      if (ends_window) begin
         windows_closed = windows_closed + 1'b1;
         ends_test = (windows_closed >= hts_pkg::WINDOWS_PER_TEST);
      end
      faults_now = fault_tally;
      if (ends_test) begin
         heater_on      = 1'b0;
         test_passed    = (fault_tally <= settings.fault_limit);
         windows_closed = '0;
         fault_tally    = '0;
         tests_finished++;
      end
      report.heater_drive = heater_on;
      report.test_done    = ends_test;
      report.heater_ok    = test_passed;
      report.faults_seen  = faults_now;
      return report;
   endfunction

   // Chooses the next reading from the shadow state: window content while a
   // window is open, otherwise a probe that faults with the given odds.
   function automatic sample_type pick_sample(input int fault_pct);
      int v;
      int lo;
      int hi;
      bit below_ok;
      bit above_ok;
      bit good_ok;
      lo = int'(settings.probe_low_limit);
      hi = int'(settings.probe_high_limit);
      if (in_window) begin
         v = window_level + int'($urandom_range(2 * window_jitter)) - window_jitter;
         if (v < 0) v = 0;
         if (v > SAMPLE_MAX) v = SAMPLE_MAX;
         return sample_type'(v);
      end
      below_ok = (lo != 0);
      above_ok = (hi != SAMPLE_MAX);
      good_ok  = (lo <= hi);
      if ((below_ok || above_ok) && (!good_ok || $urandom_range(99) < fault_pct)) begin
         if (below_ok && (!above_ok || $urandom_range(1) == 1))
            return sample_type'($urandom_range(lo - 1, 0));
         return sample_type'($urandom_range(SAMPLE_MAX, hi + 1));
      end
      case ($urandom_range(9))
         0: begin
            window_level  = 0;
            window_jitter = 0;
         end
         1: begin
            window_level  = SAMPLE_MAX;
            window_jitter = 0;
         end
         default: begin
            window_level  = int'($urandom_range(SAMPLE_MAX));
            window_jitter = int'($urandom_range(80));
         end
      endcase
      return sample_type'($urandom_range(hi, lo));
   endfunction

   // Called at a clock edge; the enable stays high until the next transaction or drain.
   task automatic write_register(input csr_idx_type idx, input csr_data_type data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         hts_pkg::CSR_PROBE_LOW:
            settings.probe_low_limit   = data[hts_pkg::SAMPLE_W-1:0];
         hts_pkg::CSR_PROBE_HIGH:
            settings.probe_high_limit  = data[hts_pkg::SAMPLE_W-1:0];
         hts_pkg::CSR_ON_SUM:
            settings.on_sum_threshold  = data[hts_pkg::SUM_W-1:0];
         hts_pkg::CSR_OFF_SUM:
            settings.off_sum_threshold = data[hts_pkg::SUM_W-1:0];
         hts_pkg::CSR_FAULT_LIM:
            settings.fault_limit       = data[hts_pkg::FAULT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_sample(input sample_type reading);
      csr_write_enable <= 1'b0;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= reading;
      do @(posedge clock); while (!req_ready);
      awaited_reports.push_back(predict_report(reading));
   endtask

   task automatic wait_for_drain();
      req_valid        <= 1'b0;
      csr_write_enable <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      // The idle tail keeps register writes clear of any remaining work.
      repeat (3) @(posedge clock);
   endtask

   task automatic run_samples(input int count, input int fault_pct);
      repeat (count) send_sample(pick_sample(fault_pct));
   endtask

   task automatic run_to_test_end(input int fault_pct);
      int start;
      start = tests_finished;
      while (tests_finished == start) send_sample(pick_sample(fault_pct));
   endtask

   task automatic program_random_settings();
      int lo;
      int hi;
      int on_sum;
      int off_sum;
      int lim;
      case ($urandom_range(5))
         0: begin
            lo = 0;
            hi = SAMPLE_MAX;
         end
         1: begin
            lo = SAMPLE_MAX;
            hi = 0;
         end
         default: begin
            lo = int'($urandom_range(300));
            hi = int'($urandom_range(SAMPLE_MAX, 700));
         end
      endcase
      case ($urandom_range(5))
         0: begin
            on_sum  = 0;
            off_sum = int'(CSR_ALL_ONES);
         end
         1: begin
            on_sum  = int'(CSR_ALL_ONES);
            off_sum = 0;
         end
         2: begin
            on_sum  = int'($urandom_range(102300));
            off_sum = on_sum;
         end
         default: begin
            on_sum  = int'($urandom_range(80000));
            off_sum = on_sum + int'($urandom_range(30000));
         end
      endcase
      case ($urandom_range(3))
         0: lim = 0;
         1: lim = int'(hts_pkg::FAULT_SATURATE);
         default: lim = int'($urandom_range(250));
      endcase
      write_register(hts_pkg::CSR_PROBE_LOW, csr_data_type'(lo));
      write_register(hts_pkg::CSR_PROBE_HIGH, csr_data_type'(hi));
      write_register(hts_pkg::CSR_ON_SUM, csr_data_type'(on_sum));
      write_register(hts_pkg::CSR_OFF_SUM, csr_data_type'(off_sum));
      write_register(hts_pkg::CSR_FAULT_LIM, csr_data_type'(lim));
   endtask

   // Probes just outside and at the edges of the reset band, then windows whose
   // sums land exactly on the reset thresholds.
   task automatic test_probe_boundaries();
      send_sample('0);
      send_sample(hts_pkg::PROBE_LOW_RESET - 1'b1);
      send_sample(hts_pkg::PROBE_HIGH_RESET + 1'b1);
      send_sample(sample_type'(SAMPLE_MAX));
      send_sample(hts_pkg::PROBE_LOW_RESET);
      repeat (hts_pkg::SAMPLES_PER_AVERAGE) send_sample('0);
      send_sample(hts_pkg::PROBE_HIGH_RESET);
      repeat (hts_pkg::SAMPLES_PER_AVERAGE) send_sample(sample_type'(SAMPLE_MAX));
   endtask

   task automatic test_threshold_overlap();
      wait_for_drain();
      // No sum can reach the off threshold, so every window turns the heater on.
      write_register(hts_pkg::CSR_ON_SUM, CSR_ALL_ONES);
      write_register(hts_pkg::CSR_OFF_SUM, CSR_ALL_ONES);
      send_sample(sample_type'(SAMPLE_MAX / 2));
      repeat (hts_pkg::SAMPLES_PER_AVERAGE) send_sample(sample_type'($urandom));
      wait_for_drain();
      // Both conditions now hold for every sum; off must win.
      write_register(hts_pkg::CSR_OFF_SUM, '0);
      send_sample(sample_type'(SAMPLE_MAX / 2));
      repeat (hts_pkg::SAMPLES_PER_AVERAGE) send_sample(sample_type'($urandom));
   endtask

   task automatic test_register_port();
      wait_for_drain();
      for (int i = int'(hts_pkg::CSR_FAULT_LIM) + 1; i < (1 << hts_pkg::CSR_IDX_W); i++)
         write_register(csr_idx_type'(i), csr_data_type'($urandom));
      // Upper data bits beyond each register's width must be dropped.
      write_register(hts_pkg::CSR_PROBE_LOW,
                     {{(hts_pkg::CSR_W - hts_pkg::SAMPLE_W){1'b1}}, sample_type'(5)});
      write_register(hts_pkg::CSR_PROBE_HIGH,
                     {{(hts_pkg::CSR_W - hts_pkg::SAMPLE_W){1'b1}}, sample_type'(1000)});
      write_register(hts_pkg::CSR_FAULT_LIM,
                     {{(hts_pkg::CSR_W - hts_pkg::FAULT_W){1'b1}}, fault_type'(3)});
      send_sample(sample_type'(4));
      send_sample(sample_type'(1001));
      send_sample(sample_type'(5));
      repeat (hts_pkg::SAMPLES_PER_AVERAGE) send_sample(sample_type'($urandom));
   endtask

   task automatic test_verdict_boundary();
      wait_for_drain();
      // An empty band makes every probe a fault, so a test ends in few transactions.
      write_register(hts_pkg::CSR_PROBE_LOW, csr_data_type'(512));
      write_register(hts_pkg::CSR_PROBE_HIGH, csr_data_type'(511));
      write_register(hts_pkg::CSR_FAULT_LIM, csr_data_type'(hts_pkg::WINDOWS_PER_TEST));
      run_to_test_end(100);
      run_to_test_end(100);
      wait_for_drain();
      write_register(hts_pkg::CSR_FAULT_LIM,
                     csr_data_type'(hts_pkg::WINDOWS_PER_TEST - 1'b1));
      run_to_test_end(100);
   endtask

   task automatic test_output_backpressure();
      wait_for_drain();
      program_random_settings();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 300;
      run_samples(60, 90);
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         wait_for_drain();
         program_random_settings();
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 50;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 50;
            end
            default: begin
               send_idle_pct = 6;
               rsp_stall_pct = 6;
            end
         endcase
         run_samples(80, int'($urandom_range(98, 80)));
      end
   endtask

   initial begin
      reset_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_probe_boundaries();
      test_threshold_overlap();
      test_register_port();
      test_verdict_boundary();
      test_output_backpressure();
      test_random_phases();
      wait_for_drain();
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
